@@ src/xcpf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package xcpf_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hFA;
   localparam logic [7:0] SYNC_SECOND = 8'hFF;

   localparam int BURST_DEPTH = 7;
   localparam int COUNT_W     = $clog2(BURST_DEPTH + 1);

   typedef enum logic {
      ACTION_START   = 1'b0,
      ACTION_PAYLOAD = 1'b1
   } action_type;

   typedef struct packed {
      logic [BURST_DEPTH-1:0][7:0] bytes;
      logic [COUNT_W-1:0]          count;
      logic                        checksum;
   } burst_type;

endpackage

`default_nettype wire

@@ src/xcpf_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xcpf_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              action,
   input  wire logic [7:0]        command_code,
   input  wire logic [7:0]        status_code,
   input  wire logic [15:0]       payload_length,
   input  wire logic [7:0]        payload_byte,
   output xcpf_pkg::burst_type    burst
);
   import xcpf_pkg::*;

   logic        in_frame_ff, in_frame_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [7:0]  xor_ff, xor_in;

   logic [15:0] size;
   logic [7:0]  header_xor;
   logic [7:0]  payload_xor;
   logic [15:0] remaining_dec;

   always_comb begin
      size          = payload_length + 16'd1;
      header_xor    = command_code ^ status_code;
      payload_xor   = xor_ff ^ payload_byte;
      remaining_dec = remaining_ff - 16'd1;

      in_frame_in  = in_frame_ff;
      remaining_in = remaining_ff;
      xor_in       = xor_ff;
      burst        = '0;

      if (action_type'(action) == ACTION_START) begin
         burst.bytes[0] = SYNC_FIRST;
         burst.bytes[1] = SYNC_SECOND;
         burst.bytes[2] = command_code;
         burst.bytes[3] = status_code;
         burst.bytes[4] = size[7:0];
         burst.bytes[5] = size[15:8];
         burst.bytes[6] = header_xor;
         xor_in         = header_xor;
         if (payload_length == 16'd0) begin
            burst.count    = COUNT_W'(7);
            burst.checksum = 1'b1;
            in_frame_in    = 1'b0;
            remaining_in   = 16'd0;
         end else begin
            burst.count    = COUNT_W'(6);
            in_frame_in    = 1'b1;
            remaining_in   = payload_length;
         end
      end else if (in_frame_ff) begin
         burst.bytes[0] = payload_byte;
         burst.bytes[1] = payload_xor;
         xor_in         = payload_xor;
         remaining_in   = remaining_dec;
         if (remaining_dec == 16'd0) begin
            burst.count    = COUNT_W'(2);
            burst.checksum = 1'b1;
            in_frame_in    = 1'b0;
         end else begin
            burst.count    = COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         remaining_ff <= 16'd0;
         xor_ff       <= 8'd0;
      end else if (accept) begin
         in_frame_ff  <= in_frame_in;
         remaining_ff <= remaining_in;
         xor_ff       <= xor_in;
      end
   end

endmodule

`default_nettype wire

@@ src/xcpf_serializer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xcpf_serializer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire xcpf_pkg::burst_type burst,
   output logic                   empty_next,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_last
);
   import xcpf_pkg::*;

   logic [BURST_DEPTH-1:0][7:0] bytes_ff, bytes_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic                        checksum_ff, checksum_in;
   logic                        fire;

   always_comb begin
      rsp_valid    = count_ff != '0;
      fire         = rsp_valid && rsp_ready;
      empty_next   = (count_ff == '0) || (count_ff == COUNT_W'(1) && rsp_ready);
      rsp_out_byte = bytes_ff[0];
      rsp_out_last = checksum_ff && (count_ff == COUNT_W'(1));

      bytes_in    = bytes_ff;
      count_in    = count_ff;
      checksum_in = checksum_ff;
      if (load) begin
         bytes_in    = burst.bytes;
         count_in    = burst.count;
         checksum_in = burst.checksum;
      end else if (fire) begin
         bytes_in    = bytes_ff >> 8;
         count_in    = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff    <= bytes_in;
      checksum_ff <= checksum_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ src/xor_checksum_packet_framer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Packet framer: a start request (action 0) emits the sync bytes 0xFA 0xFF,
// command, status and the little-endian size (payload_length + 1); each
// payload request (action 1) inside a frame passes its byte through, and the
// final one is followed by the XOR checksum of command, status and payload,
// flagged with rsp_out_last. A zero-length start emits header and checksum
// together. Payload outside a frame is dropped; a new start abandons an open
// frame. Output runs one byte per cycle while rsp_ready is high: a payload
// request emits one byte (two for the last one), a start six bytes (seven
// with zero length), through the single-byte output shifter; the next request
// is taken as the last byte of the current burst leaves.
module xor_checksum_packet_framer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_command_code,
   input  wire logic [7:0]  req_status_code,
   input  wire logic [15:0] req_payload_length,
   input  wire logic [7:0]  req_payload_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last
);
   import xcpf_pkg::*;

   burst_type burst;
   logic      accept;
   logic      empty_next;

   assign req_ready = empty_next;
   assign accept    = req_valid && req_ready;

   xcpf_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .action         (req_action),
      .command_code   (req_command_code),
      .status_code    (req_status_code),
      .payload_length (req_payload_length),
      .payload_byte   (req_payload_byte),
      .burst          (burst)
   );

   xcpf_serializer u_serializer (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .burst        (burst),
      .empty_next   (empty_next),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

`default_nettype wire

@@ src/xcpf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xcpf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_action,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_out_last
);
   import xcpf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_last))
      else $error("rsp changed while stalled");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready with output empty");

   a_start_sync: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACTION_START
         |=> rsp_valid && rsp_out_byte == SYNC_FIRST && !rsp_out_last)
      else $error("start request did not open with sync");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind xor_checksum_packet_framer xcpf_checker u_xcpf_checker (.*);

`default_nettype wire
